### src/point_to_segment_distance_core_defines.svh
// ---------------------------------------------------------------------------
// Point to segment distance: assertion macros
// Shared property forms, clocked on clk and disabled during rst.
// ---------------------------------------------------------------------------
`ifndef POINT_TO_SEGMENT_DISTANCE_CORE_DEFINES_SVH
`define POINT_TO_SEGMENT_DISTANCE_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/psd_pkg.sv
// ---------------------------------------------------------------------------
// Point to segment distance package
// Default sizes, result widths and region codes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package psd_pkg;

  localparam int COORD_BITS_DEF      = 24;
  localparam int PARAM_FRAC_BITS_DEF = 16;
  localparam int DIST_W              = 25;
  localparam int REGION_W            = 2;

  typedef enum logic [REGION_W-1:0] {
    REGION_BEFORE = 2'd0,
    REGION_ON     = 2'd1,
    REGION_PAST   = 2'd2,
    REGION_DEGEN  = 2'd3
  } region_t;

endpackage

### src/point_to_segment_distance_core.sv
// ---------------------------------------------------------------------------
// Point to segment distance core
// Distance from a query point to a 2-D segment, with a region code.
// ---------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry the segment start, segment end and
// query point. Output channel: out_valid/out_stall carry distance and region.
// An item moves on a rising edge where valid is high and stall is low.
// The datapath is a row of registered stages: four stages form differences,
// products, dot and squared length and the region; a chain of
// PARAM_FRAC_BITS+1 division cells forms the projection parameter one bit
// per cell; four stages form the nearest point, offsets and squared
// distance; a chain of COORD_BITS+2 root cells forms the distance.
// Throughput: one item per cycle while out_stall is low.
// Each stage loads whenever it is empty or the stage after it moves, so a
// stalled receiver holds the last cell while items behind it close up the
// gaps; in_stall rises only once every stage is full.
// Reset empties all stages; payload registers keep whatever they hold.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_to_segment_distance_core #(
  parameter int COORD_BITS      = psd_pkg::COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = psd_pkg::PARAM_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  start_x,
  input  logic signed [COORD_BITS-1:0]  start_y,
  input  logic signed [COORD_BITS-1:0]  end_x,
  input  logic signed [COORD_BITS-1:0]  end_y,
  input  logic signed [COORD_BITS-1:0]  query_x,
  input  logic signed [COORD_BITS-1:0]  query_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [psd_pkg::DIST_W-1:0]    distance,
  output logic [psd_pkg::REGION_W-1:0]  region
);

  import psd_pkg::*;

  `include "point_to_segment_distance_core_defines.svh"

  localparam int CW     = COORD_BITS;
  localparam int PFB    = PARAM_FRAC_BITS;
  localparam int DW     = CW + 1;
  localparam int PW     = 2 * DW;
  localparam int LENW   = PW;
  localparam int DOTW   = PW + 1;
  localparam int RW     = LENW + 1;
  localparam int TW     = PFB + 1;
  localparam int OW     = TW + 1 + DW;
  localparam int XW     = CW + 2;
  localparam int ROOT_W = XW;
  localparam int SQW    = 2 * ROOT_W;
  localparam int DIV_N  = TW;
  localparam int SQ_N   = ROOT_W;
  localparam int SIDE_W = 6 * CW + 2 * DW + REGION_W;
  localparam logic [TW-1:0] T_ONE = {1'b1, {PFB{1'b0}}};

  // ---- stage 1: differences
  logic                 s1_valid, s1_ready;
  logic signed [CW-1:0] s1_sx, s1_sy, s1_ex, s1_ey, s1_px, s1_py;
  logic signed [DW-1:0] s1_a, s1_b, s1_c, s1_d;
  // ---- stage 2: products
  logic                 s2_valid, s2_ready;
  logic signed [CW-1:0] s2_sx, s2_sy, s2_ex, s2_ey, s2_px, s2_py;
  logic signed [DW-1:0] s2_c, s2_d;
  logic signed [PW-1:0] s2_ac, s2_bd, s2_cc, s2_dd;
  // ---- stage 3: dot and squared length
  logic                   s3_valid, s3_ready;
  logic signed [CW-1:0]   s3_sx, s3_sy, s3_ex, s3_ey, s3_px, s3_py;
  logic signed [DW-1:0]   s3_c, s3_d;
  logic signed [DOTW-1:0] s3_dot;
  logic [LENW-1:0]        s3_len;
  // ---- stage 4: region and division start
  logic                 s4_valid, s4_ready;
  logic [RW-1:0]        s4_r;
  logic [LENW-1:0]      s4_len;
  logic [SIDE_W-1:0]    s4_side;
  logic [DOTW-1:0]      mag;
  logic [LENW-1:0]      cl;
  logic                 neg;
  region_t              reg_next;
  logic [RW-1:0]        r_next;

  // ---- division chain
  logic                d_v     [DIV_N+1];
  logic                d_rdy   [DIV_N];
  logic [RW-1:0]       d_r     [DIV_N+1];
  logic [LENW-1:0]     d_len   [DIV_N+1];
  logic [TW-1:0]       d_q     [DIV_N+1];
  logic [SIDE_W-1:0]   d_side  [DIV_N+1];

  logic signed [CW-1:0]     u_sx, u_sy, u_ex, u_ey, u_px, u_py;
  logic signed [DW-1:0]     u_c, u_d;
  logic [REGION_W-1:0]      u_region;

  // ---- stage 5: offset products
  logic                  s5_valid, s5_ready;
  logic signed [CW-1:0]  s5_sx, s5_sy, s5_ex, s5_ey, s5_px, s5_py;
  logic signed [OW-1:0]  s5_ox, s5_oy;
  region_t               s5_region;
  // ---- stage 6: nearest point and deltas
  logic                  s6_valid, s6_ready;
  logic signed [XW-1:0]  s6_dx, s6_dy;
  region_t               s6_region;
  logic signed [OW-1:0]  offx, offy;
  logic signed [XW-1:0]  nx, ny;
  // ---- stage 7: squares
  logic                   s7_valid, s7_ready;
  logic signed [2*XW-1:0] s7_sqx, s7_sqy;
  region_t                s7_region;
  // ---- stage 8: squared distance
  logic                  s8_valid, s8_ready;
  logic [SQW-1:0]        s8_sq;
  region_t               s8_region;

  // ---- root chain
  logic                 q_v    [SQ_N+1];
  logic                 q_rdy  [SQ_N];
  logic [SQW-1:0]       q_n    [SQ_N+1];
  logic [ROOT_W+1:0]    q_rem  [SQ_N+1];
  logic [ROOT_W-1:0]    q_root [SQ_N+1];
  logic [REGION_W-1:0]  q_side [SQ_N+1];

  // ---- ready chain: a stage loads when empty or when the next one moves
  assign q_rdy[SQ_N-1] = !q_v[SQ_N] || !out_stall;
  for (genvar k = 0; k < SQ_N - 1; k++) begin : g_qrdy
    assign q_rdy[k] = !q_v[k+1] || q_rdy[k+1];
  end
  assign s8_ready = !s8_valid || q_rdy[0];
  assign s7_ready = !s7_valid || s8_ready;
  assign s6_ready = !s6_valid || s7_ready;
  assign s5_ready = !s5_valid || s6_ready;
  assign d_rdy[DIV_N-1] = !d_v[DIV_N] || s5_ready;
  for (genvar k = 0; k < DIV_N - 1; k++) begin : g_drdy
    assign d_rdy[k] = !d_v[k+1] || d_rdy[k+1];
  end
  assign s4_ready = !s4_valid || d_rdy[0];
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;

  // ---- valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
      s6_valid <= 1'b0;
      s7_valid <= 1'b0;
      s8_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= in_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
      if (s4_ready) s4_valid <= s3_valid;
      if (s5_ready) s5_valid <= d_v[DIV_N];
      if (s6_ready) s6_valid <= s5_valid;
      if (s7_ready) s7_valid <= s6_valid;
      if (s8_ready) s8_valid <= s7_valid;
    end
  end

  // ---- stages 1 to 4
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_sx <= start_x;
      s1_sy <= start_y;
      s1_ex <= end_x;
      s1_ey <= end_y;
      s1_px <= query_x;
      s1_py <= query_y;
      s1_a  <= DW'(query_x) - DW'(start_x);
      s1_b  <= DW'(query_y) - DW'(start_y);
      s1_c  <= DW'(end_x) - DW'(start_x);
      s1_d  <= DW'(end_y) - DW'(start_y);
    end
    if (s2_ready) begin
      s2_sx <= s1_sx;
      s2_sy <= s1_sy;
      s2_ex <= s1_ex;
      s2_ey <= s1_ey;
      s2_px <= s1_px;
      s2_py <= s1_py;
      s2_c  <= s1_c;
      s2_d  <= s1_d;
      s2_ac <= PW'(s1_a) * PW'(s1_c);
      s2_bd <= PW'(s1_b) * PW'(s1_d);
      s2_cc <= PW'(s1_c) * PW'(s1_c);
      s2_dd <= PW'(s1_d) * PW'(s1_d);
    end
    if (s3_ready) begin
      s3_sx  <= s2_sx;
      s3_sy  <= s2_sy;
      s3_ex  <= s2_ex;
      s3_ey  <= s2_ey;
      s3_px  <= s2_px;
      s3_py  <= s2_py;
      s3_c   <= s2_c;
      s3_d   <= s2_d;
      s3_dot <= DOTW'(s2_ac) + DOTW'(s2_bd);
      s3_len <= $unsigned(s2_cc + s2_dd);
    end
    if (s4_ready) begin
      s4_r    <= r_next;
      s4_len  <= s3_len;
      s4_side <= {s3_sx, s3_sy, s3_ex, s3_ey, s3_px, s3_py, s3_c, s3_d, reg_next};
    end
  end

  // Classify by t without dividing: compare |dot| against len and ceil(len/2^PFB).
  assign neg = s3_dot[DOTW-1];
  assign mag = neg ? $unsigned(-s3_dot) : $unsigned(s3_dot);
  assign cl  = (s3_len >> PFB) + LENW'(|s3_len[PFB-1:0]);

  always_comb begin
    if (s3_len == '0) begin
      reg_next = REGION_DEGEN;
    end else if (neg && (mag >= DOTW'(cl))) begin
      reg_next = REGION_BEFORE;
    end else if (!neg && (mag > DOTW'(s3_len)) && ((mag - DOTW'(s3_len)) >= DOTW'(cl))) begin
      reg_next = REGION_PAST;
    end else begin
      reg_next = REGION_ON;
    end
    // a tiny negative projection divides as zero
    r_next = ((reg_next == REGION_ON) && !neg) ? RW'(mag) : '0;
  end

  // ---- division chain
  assign d_v[0]    = s4_valid;
  assign d_r[0]    = s4_r;
  assign d_len[0]  = s4_len;
  assign d_q[0]    = '0;
  assign d_side[0] = s4_side;

  for (genvar k = 0; k < DIV_N; k++) begin : g_div
    psd_div_cell #(
      .RW     (RW),
      .LENW   (LENW),
      .TW     (TW),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (d_rdy[k]),
      .in_valid  (d_v[k]),
      .in_r      (d_r[k]),
      .in_len    (d_len[k]),
      .in_q      (d_q[k]),
      .in_side   (d_side[k]),
      .out_valid (d_v[k+1]),
      .out_r     (d_r[k+1]),
      .out_len   (d_len[k+1]),
      .out_q     (d_q[k+1]),
      .out_side  (d_side[k+1])
    );
  end

  assign {u_sx, u_sy, u_ex, u_ey, u_px, u_py, u_c, u_d, u_region} = d_side[DIV_N];

  // ---- stages 5 to 8
  assign offx = s5_ox >>> PFB;
  assign offy = s5_oy >>> PFB;

  always_comb begin
    case (s5_region)
      REGION_ON: begin
        nx = XW'(s5_sx) + XW'(offx);
        ny = XW'(s5_sy) + XW'(offy);
      end
      REGION_PAST: begin
        nx = XW'(s5_ex);
        ny = XW'(s5_ey);
      end
      default: begin
        nx = XW'(s5_sx);
        ny = XW'(s5_sy);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s5_ready) begin
      s5_sx     <= u_sx;
      s5_sy     <= u_sy;
      s5_ex     <= u_ex;
      s5_ey     <= u_ey;
      s5_px     <= u_px;
      s5_py     <= u_py;
      s5_ox     <= $signed({1'b0, d_q[DIV_N]}) * u_c;
      s5_oy     <= $signed({1'b0, d_q[DIV_N]}) * u_d;
      s5_region <= region_t'(u_region);
    end
    if (s6_ready) begin
      s6_dx     <= XW'(s5_px) - nx;
      s6_dy     <= XW'(s5_py) - ny;
      s6_region <= s5_region;
    end
    if (s7_ready) begin
      s7_sqx    <= (2*XW)'(s6_dx) * (2*XW)'(s6_dx);
      s7_sqy    <= (2*XW)'(s6_dy) * (2*XW)'(s6_dy);
      s7_region <= s6_region;
    end
    if (s8_ready) begin
      s8_sq     <= $unsigned(s7_sqx) + $unsigned(s7_sqy);
      s8_region <= s7_region;
    end
  end

  // ---- root chain; the last cell is the output register
  assign q_v[0]    = s8_valid;
  assign q_n[0]    = s8_sq;
  assign q_rem[0]  = '0;
  assign q_root[0] = '0;
  assign q_side[0] = s8_region;

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    psd_sqrt_cell #(
      .ROOT_W (ROOT_W),
      .SIDE_W (REGION_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (q_rdy[k]),
      .in_valid  (q_v[k]),
      .in_n      (q_n[k]),
      .in_rem    (q_rem[k]),
      .in_root   (q_root[k]),
      .in_side   (q_side[k]),
      .out_valid (q_v[k+1]),
      .out_n     (q_n[k+1]),
      .out_rem   (q_rem[k+1]),
      .out_root  (q_root[k+1]),
      .out_side  (q_side[k+1])
    );
  end

  assign out_valid = q_v[SQ_N];
  assign distance  = DIST_W'(q_root[SQ_N]);
  assign region    = q_side[SQ_N];

  // ---- checks
  `PSD_ASSERT_IMP(a_div_start_bound, s4_valid, (s4_r == '0) || (s4_r < {s4_len, 1'b0}), "division start not below twice the length")
  `PSD_ASSERT_IMP(a_param_bound, d_v[DIV_N] && (u_region == REGION_ON), d_q[DIV_N] <= T_ONE, "projection parameter above one")
  `PSD_ASSERT_NXT(a_root_entry, s8_valid && q_rdy[0], q_v[1], "squared distance item lost at root chain entry")
  `PSD_ASSERT_IMP(a_degen_no_div, s4_valid && (s4_len == '0), s4_r == '0, "zero-length segment entered the divider")

endmodule

### src/psd_div_cell.sv
// ---------------------------------------------------------------------------
// Division cell
// One restoring quotient bit per cell; remainder and side data move on.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_div_cell #(
  parameter int RW     = 51,
  parameter int LENW   = 50,
  parameter int TW     = 17,
  parameter int SIDE_W = 200
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              in_valid,
  input  logic [RW-1:0]     in_r,
  input  logic [LENW-1:0]   in_len,
  input  logic [TW-1:0]     in_q,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [RW-1:0]     out_r,
  output logic [LENW-1:0]   out_len,
  output logic [TW-1:0]     out_q,
  output logic [SIDE_W-1:0] out_side
);

  logic          ge;
  logic [RW-1:0] rem;

  assign ge  = in_r >= {1'b0, in_len};
  assign rem = ge ? (in_r - {1'b0, in_len}) : in_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r    <= {rem[RW-2:0], 1'b0};
      out_len  <= in_len;
      out_q    <= {in_q[TW-2:0], ge};
      out_side <= in_side;
    end
  end

endmodule

### src/psd_sqrt_cell.sv
// ---------------------------------------------------------------------------
// Square root cell
// One root bit per cell from the next two radicand bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module psd_sqrt_cell #(
  parameter int ROOT_W = 26,
  parameter int SIDE_W = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  logic                in_valid,
  input  logic [2*ROOT_W-1:0] in_n,
  input  logic [ROOT_W+1:0]   in_rem,
  input  logic [ROOT_W-1:0]   in_root,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [2*ROOT_W-1:0] out_n,
  output logic [ROOT_W+1:0]   out_rem,
  output logic [ROOT_W-1:0]   out_root,
  output logic [SIDE_W-1:0]   out_side
);

  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic              ge;

  assign rem_sh = {in_rem[ROOT_W-1:0], in_n[2*ROOT_W-1:2*ROOT_W-2]};
  assign trial  = {in_root, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_n    <= {in_n[2*ROOT_W-3:0], 2'b00};
      out_rem  <= ge ? (rem_sh - trial) : rem_sh;
      out_root <= {in_root[ROOT_W-2:0], ge};
      out_side <= in_side;
    end
  end

endmodule
